### rtl/sdc_pkg.sv
// shared types and constants for the stencil first-derivative core
// no dependencies; imported by every module of the block

package sdc_pkg;

  // configuration register
  localparam int unsigned GAIN_WIDTH = 20;
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 20'd4096;

  // extra bits a stencil sum needs over a sample (coefficient magnitudes sum to at most 128)
  localparam int unsigned STENCIL_GROWTH = 8;

  // results one sample can cause, and the width of that count
  localparam int unsigned MAX_PUSH = 5;
  localparam int unsigned PUSH_CNT_W = 3;

  // samples of a stream before the centred stencil applies, and the saturated count
  localparam logic [2:0] SEEN_WARMUP = 3'd4;
  localparam logic [2:0] SEEN_FULL   = 3'd5;

  // result queue between the stencil and the scaling pipeline
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QIDX_W      = 3;
  localparam int unsigned QCNT_W      = 4;

  // per-result marks that travel with a stencil sum
  typedef struct packed {
    logic last;
    logic too_short;
  } sdc_flags_t;

  // what one accepted sample adds to the result queue
  typedef struct packed {
    logic [PUSH_CNT_W-1:0] num;
    logic                  last;
    logic                  too_short;
  } sdc_push_t;

endpackage

### rtl/sdc_stencil.sv
// sample window, stream counter and the five stencil sums
// depends on sdc_pkg

module sdc_stencil import sdc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  localparam int SumW = SAMPLE_WIDTH + STENCIL_GROWTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           eos_i,
  output logic signed [SumW-1:0]         sum_o [MAX_PUSH],
  output sdc_push_t                      push_o
);

  localparam logic signed [SumW-1:0] K3  = SumW'(3);
  localparam logic signed [SumW-1:0] K6  = SumW'(6);
  localparam logic signed [SumW-1:0] K8  = SumW'(8);
  localparam logic signed [SumW-1:0] K10 = SumW'(10);
  localparam logic signed [SumW-1:0] K16 = SumW'(16);
  localparam logic signed [SumW-1:0] K18 = SumW'(18);
  localparam logic signed [SumW-1:0] K25 = SumW'(25);
  localparam logic signed [SumW-1:0] K36 = SumW'(36);
  localparam logic signed [SumW-1:0] K48 = SumW'(48);

  logic signed [SAMPLE_WIDTH-1:0] win_q [4];
  logic [2:0]                     seen_q, seen_d;
  logic signed [SumW-1:0]         sa, sb, sc, sd, se;
  logic signed [SumW-1:0]         fwd0, fwd1, cen, bwd1, bwd0;

  // oldest to newest, the incoming sample completes the window
  assign sa = SumW'(win_q[0]);
  assign sb = SumW'(win_q[1]);
  assign sc = SumW'(win_q[2]);
  assign sd = SumW'(win_q[3]);
  assign se = SumW'(sample_i);

  // one-sided stencils at the stream edges, centred stencil inside
  assign fwd0 = K48 * sb + K16 * sd - K25 * sa - K36 * sc - K3 * se;
  assign fwd1 = K18 * sc + se - K3 * sa - K10 * sb - K6 * sd;
  assign cen  = K8 * (sd - sb) + sa - se;
  assign bwd1 = K3 * se + K10 * sd + K6 * sb - K18 * sc - sa;
  assign bwd0 = K25 * se + K36 * sc + K3 * sa - K48 * sd - K16 * sb;

  // results caused by this transaction, in emission order
  always_comb begin
    for (int j = 0; j < MAX_PUSH; j++) begin
      sum_o[j] = '0;
    end
    push_o = '0;
    if (accept_i) begin
      push_o.last = eos_i;
      if (seen_q < SEEN_WARMUP) begin
        if (eos_i) begin
          push_o.num       = PUSH_CNT_W'(1);
          push_o.too_short = 1'b1;
        end
      end else if (seen_q == SEEN_WARMUP) begin
        sum_o[0]   = fwd0;
        sum_o[1]   = fwd1;
        sum_o[2]   = cen;
        sum_o[3]   = bwd1;
        sum_o[4]   = bwd0;
        push_o.num = eos_i ? PUSH_CNT_W'(5) : PUSH_CNT_W'(3);
      end else begin
        sum_o[0]   = cen;
        sum_o[1]   = bwd1;
        sum_o[2]   = bwd0;
        push_o.num = eos_i ? PUSH_CNT_W'(3) : PUSH_CNT_W'(1);
      end
    end
  end

  // stream counter, restarts after an end mark
  always_comb begin
    seen_d = seen_q;
    if (accept_i) begin
      if (eos_i) begin
        seen_d = '0;
      end else if (seen_q < SEEN_WARMUP) begin
        seen_d = seen_q + 3'd1;
      end else begin
        seen_d = SEEN_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // window shift; contents are only used once four samples of a stream are in
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= sample_i;
    end
  end

endmodule

### rtl/sdc_scale.sv
// two-stage gain multiply, round to nearest and saturate
// depends on sdc_pkg

module sdc_scale import sdc_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int RESULT_WIDTH   = 24,
  parameter int GAIN_FRAC_BITS = 12,
  localparam int SumW = SAMPLE_WIDTH + STENCIL_GROWTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  logic                           pop_i,
  input  logic signed [SumW-1:0]         sum_i,
  input  sdc_flags_t                     flags_i,
  input  logic [GAIN_WIDTH-1:0]          gain_i,
  output logic                           out_valid_o,
  output logic signed [RESULT_WIDTH-1:0] derivative_o,
  output sdc_flags_t                     flags_o,
  output logic                           saturated_o
);

  localparam int ProdW = SumW + GAIN_WIDTH;
  localparam int CmpW  = (ProdW + 1 > RESULT_WIDTH + 1) ? ProdW + 1 : RESULT_WIDTH + 1;
  localparam logic [ProdW:0]  ROUND_ADD = ((ProdW + 1)'(1) << GAIN_FRAC_BITS) >> 1;
  localparam logic [CmpW-1:0] LIM_NEG   = CmpW'(1) << (RESULT_WIDTH - 1);
  localparam logic [CmpW-1:0] LIM_POS   = LIM_NEG - CmpW'(1);

  logic [SumW-1:0]  mag;
  logic [ProdW-1:0] prod_d, prod_q;
  logic             neg_q;
  sdc_flags_t       flags_q;
  logic             mv_q;

  logic [ProdW:0]   rnd;
  logic [ProdW:0]   shv;
  logic [CmpW-1:0]  ext, clip, val;
  logic             sat;

  // stage one: magnitude times gain
  assign mag    = sum_i[SumW-1] ? (~sum_i + 1'b1) : sum_i;
  assign prod_d = ProdW'(mag) * ProdW'(gain_i);

  // stage two: round half away from zero on the magnitude, clip, restore sign
  assign rnd = (ProdW + 1)'(prod_q) + ROUND_ADD;
  assign shv = rnd >> GAIN_FRAC_BITS;
  assign ext = CmpW'(shv);

  always_comb begin
    clip = ext;
    sat  = 1'b0;
    if (neg_q) begin
      if (ext > LIM_NEG) begin
        clip = LIM_NEG;
        sat  = 1'b1;
      end
    end else begin
      if (ext > LIM_POS) begin
        clip = LIM_POS;
        sat  = 1'b1;
      end
    end
    val = neg_q ? (~clip + 1'b1) : clip;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (advance_i) begin
      mv_q        <= pop_i;
      out_valid_o <= mv_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q       <= prod_d;
      neg_q        <= sum_i[SumW-1];
      flags_q      <= flags_i;
      derivative_o <= val[RESULT_WIDTH-1:0];
      saturated_o  <= sat;
      flags_o      <= flags_q;
    end
  end

endmodule

### rtl/stencil_first_derivative_core.sv
// top level of the stencil first-derivative core: config register, result queue
// depends on sdc_pkg, sdc_stencil and sdc_scale

// Streams signed samples and returns the fourth-order first derivative at every
// grid point, two samples behind the input; the end-marked sample flushes the two
// final points, and a stream of fewer than five samples yields a single result
// flagged too_short. Each stencil sum is scaled by gain (GAIN_FRAC_BITS fraction
// bits), rounded half away from zero and clipped to RESULT_WIDTH bits. A sample
// is taken every cycle while the eight-entry result queue has room for the five
// results one sample can cause; results leave at one per cycle while the output
// is not stalled, so the sustained rate is one sample and one result per clock,
// and with the output free in_stall_o rises only after the burst at the end of a
// stream. A result travels from the sample that causes it through the queue,
// multiply and round stage registers. Write gain through the cfg channel only
// while the block is idle; cfg_ready_o is always high.

module stencil_first_derivative_core import sdc_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int RESULT_WIDTH   = 24,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           end_of_stream_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [RESULT_WIDTH-1:0] derivative_o,
  output logic                           last_result_o,
  output logic                           saturated_o,
  output logic                           too_short_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [GAIN_WIDTH-1:0]          cfg_data_i
);

  localparam int SumW = SAMPLE_WIDTH + STENCIL_GROWTH;

  logic [GAIN_WIDTH-1:0]  gain_q;
  logic                   accept;
  logic                   advance;
  logic                   pop;
  logic signed [SumW-1:0] push_sum [MAX_PUSH];
  sdc_push_t              push;
  sdc_flags_t             out_flags;

  logic signed [SumW-1:0] q_sum_q [QUEUE_DEPTH];
  logic signed [SumW-1:0] q_sum_d [QUEUE_DEPTH];
  sdc_flags_t             q_flags_q [QUEUE_DEPTH];
  sdc_flags_t             q_flags_d [QUEUE_DEPTH];
  logic [QCNT_W-1:0]      q_cnt_q, q_cnt_d;
  logic [QCNT_W-1:0]      base_cnt;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  // input transaction only when the queue can take a full burst
  assign in_stall_o = (q_cnt_q > QCNT_W'(QUEUE_DEPTH - MAX_PUSH));
  assign accept     = in_valid_i && !in_stall_o;

  sdc_stencil #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_stencil (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .sample_i(sample_i),
    .eos_i   (end_of_stream_i),
    .sum_o   (push_sum),
    .push_o  (push)
  );

  // output pipeline moves whenever its last stage is free or being taken
  assign advance = !out_valid_o || !out_stall_i;
  assign pop     = advance && (q_cnt_q != '0);

  // queue: shift out at the head, append the new burst after the survivors
  always_comb begin
    q_sum_d   = q_sum_q;
    q_flags_d = q_flags_q;
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        q_sum_d[i]   = q_sum_q[i+1];
        q_flags_d[i] = q_flags_q[i+1];
      end
    end
    base_cnt = q_cnt_q - QCNT_W'(pop);
    for (int j = 0; j < MAX_PUSH; j++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if ((PUSH_CNT_W'(j) < push.num) && ((base_cnt + QCNT_W'(j)) == QCNT_W'(i))) begin
          q_sum_d[i]           = push_sum[j];
          q_flags_d[i].last      = push.last &&
                                   ((push.num - PUSH_CNT_W'(1)) == PUSH_CNT_W'(j));
          q_flags_d[i].too_short = push.too_short;
        end
      end
    end
    q_cnt_d = base_cnt + QCNT_W'(push.num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
    end else begin
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_sum_q   <= q_sum_d;
    q_flags_q <= q_flags_d;
  end

  sdc_scale #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .RESULT_WIDTH  (RESULT_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .pop_i       (pop),
    .sum_i       (q_sum_q[0]),
    .flags_i     (q_flags_q[0]),
    .gain_i      (gain_q),
    .out_valid_o (out_valid_o),
    .derivative_o(derivative_o),
    .flags_o     (out_flags),
    .saturated_o (saturated_o)
  );

  assign last_result_o = out_flags.last;
  assign too_short_o   = out_flags.too_short;

endmodule
